FILE: design/bds_pkg.sv
// Shared types and constants for the 2x2 box downscaler.
// No dependencies; used by every design file but bds_ram.
package bds_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int COL_W      = 13;
  localparam int ROW_W      = 16;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = PIX_W + 1;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [COL_W-1:0] WIDTH_RESET  = COL_W'(640);
  localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(480);

  typedef logic [PIX_W-1:0]      pixel_t;
  typedef logic [SUM_W-1:0]      pair_sum_t;
  typedef logic [COL_W-1:0]      col_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [ADDR_W-1:0]     line_addr_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

endpackage

FILE: design/bds_stream_ifs.sv
// Valid/ready stream interfaces for source pixels and downscaled results.
// Depends on bds_pkg for the payload types.
interface bds_in_if;
  import bds_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface bds_out_if;
  import bds_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t pixel_out;
  logic   frame_last;
  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

FILE: design/bds_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module bds_ram #(
  parameter int W = 9,
  parameter int D = 2048,
  localparam int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/box_downscale_2x2_core.sv
// Top level of the 2x2 box downscaler: counters, line store and result stages.
// Depends on bds_pkg, bds_stream_ifs and bds_ram.
//
// Usage:
// Source pixels arrive in raster order on in_px, one transfer per pixel.
// Each 2x2 block of the plane yields one result on out_px: the block sum
// divided by four, truncated. frame_last marks the final result of a frame.
// A trailing odd column or odd row produces no result.
// The plane size is set through cfg_we/cfg_index/cfg_wdata, written while
// the block is idle. Index 0 is frame_width, index 1 is frame_height.
// Throughput is one pixel per clock while in_px.ready is high; the line store
// has one write and one read port, and each pixel needs at most one of them.
// A result reaches out_px after the transfer of the pixel that completes
// its block: the line store read and the pair sum are registered at that
// transfer, and the output register takes their sum once it is free.
// When the receiver stalls, the result waits in the output register and one
// more block can wait behind it; in_px.ready drops only when both are full.
// Reset clears the counters and restores a 640x480 plane. The line store is
// not cleared; each entry is written on an even row before it is read.
module box_downscale_2x2_core (
  input  logic                 clk,
  input  logic                 rst_n,
  bds_in_if.sink               in_px,
  bds_out_if.source            out_px,
  input  logic                 cfg_we,
  input  bds_pkg::cfg_idx_t    cfg_index,
  input  bds_pkg::cfg_data_t   cfg_wdata
);
  import bds_pkg::*;

  col_t       width_r;
  row_t       height_r;
  col_t       col_r, col_nxt;
  row_t       row_r, row_nxt;
  pixel_t     held_r;

  logic       s1_valid_r, s1_valid_nxt;
  pair_sum_t  s1_sum_r;
  logic       s1_last_r;

  logic       out_valid_r, out_valid_nxt;
  pixel_t     out_pixel_r;
  logic       out_last_r;

  col_t       w_eff, last_pair_col;
  row_t       h_eff, last_pair_row;
  logic       accept, pair_ok, line_we, line_re, s1_advance, is_last;
  pair_sum_t  pair_sum, above_sum;
  line_addr_t line_addr;
  logic [SUM_W:0] block_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  width_r  <= cfg_wdata[COL_W-1:0];
        CFG_FRAME_HEIGHT: height_r <= cfg_wdata[ROW_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff = col_t'(1);
    end else if (width_r > col_t'(MAX_WIDTH)) begin
      w_eff = col_t'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r == '0) ? row_t'(1) : height_r;
    last_pair_col = {w_eff[COL_W-1:1], 1'b0};
    last_pair_row = {h_eff[ROW_W-1:1], 1'b0};
  end

  assign s1_advance = s1_valid_r && (!out_valid_r || out_px.ready);
  assign in_px.ready = !s1_valid_r || !out_valid_r || out_px.ready;
  assign accept = in_px.valid && in_px.ready;

  assign pair_ok   = col_r[0] && (col_r < last_pair_col) && (row_r < last_pair_row);
  assign line_we   = accept && pair_ok && !row_r[0];
  assign line_re   = accept && pair_ok && row_r[0];
  assign line_addr = col_r[ADDR_W:1];
  assign pair_sum  = {1'b0, held_r} + {1'b0, in_px.pixel_in};
  assign is_last   = (col_r == last_pair_col - col_t'(1))
                  && (row_r == last_pair_row - row_t'(1));

  bds_ram #(
    .W (SUM_W),
    .D (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_addr),
    .wdata (pair_sum),
    .re    (line_re),
    .raddr (line_addr),
    .rdata (above_sum)
  );

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_r >= w_eff - col_t'(1)) begin
        col_nxt = '0;
        row_nxt = (row_r >= h_eff - row_t'(1)) ? '0 : row_r + row_t'(1);
      end else begin
        col_nxt = col_r + col_t'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (line_re) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_px.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign block_sum = {1'b0, above_sum} + {1'b0, s1_sum_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !col_r[0]) begin
      held_r <= in_px.pixel_in;
    end
    if (line_re) begin
      s1_sum_r  <= pair_sum;
      s1_last_r <= is_last;
    end
    if (s1_advance) begin
      out_pixel_r <= block_sum[SUM_W:2];
      out_last_r  <= s1_last_r;
    end
  end

  assign out_px.valid      = out_valid_r;
  assign out_px.pixel_out  = out_pixel_r;
  assign out_px.frame_last = out_last_r;

endmodule

FILE: design/bds_checker.sv
// Port-level checks for the 2x2 box downscaler, bound to its top level.
// Depends on bds_pkg and box_downscale_2x2_core.
module bds_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input bds_pkg::pixel_t   pixel_out,
  input logic              frame_last
);

  // The output register clears on reset.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // With the output register empty, nothing can hold back the source.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(frame_last))
    else $error("stalled result changed");

endmodule

bind box_downscale_2x2_core bds_checker u_bds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_px.ready),
  .out_valid  (out_px.valid),
  .out_ready  (out_px.ready),
  .pixel_out  (out_px.pixel_out),
  .frame_last (out_px.frame_last)
);
